>>> hw/rtl/sgb_pkg.sv
// Shared constants and types for the separable 5-tap Gaussian blur.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps

package sgb_pkg;

   localparam int MAX_SIDE_DEF    = 256;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int COEF_W     = 16;
   localparam int SIDE_W     = 9;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int TAPS       = 5;
   localparam int ROW_SLOTS  = 4;
   localparam int MIN_SIDE   = 5;
   localparam int FRAC_BITS  = 16;
   localparam int ROUND_BIAS = 32768;

   localparam logic [SIDE_W-1:0] SIDE_RESET   = 9'd256;
   localparam logic [COEF_W-1:0] OUTER_RESET  = 16'd88;
   localparam logic [COEF_W-1:0] NEAR_RESET   = 16'd10309;
   localparam logic [COEF_W-1:0] CENTER_RESET = 16'd44741;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_SIDE   = 2'd0;
   localparam logic [1:0] REG_OUTER  = 2'd1;
   localparam logic [1:0] REG_NEAR   = 2'd2;
   localparam logic [1:0] REG_CENTER = 2'd3;

   typedef struct packed {
      logic [COEF_W-1:0] outer;
      logic [COEF_W-1:0] near;
      logic [COEF_W-1:0] center;
   } coef_set_type;

endpackage

>>> hw/rtl/sgb_channels.sv
// Valid/ready channel interfaces for blur requests and blurred results.
// Depends on sgb_pkg for the default sample width.
`timescale 1ns / 1ps

interface sgb_req_if #(parameter int SAMPLE_BITS = sgb_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [SAMPLE_BITS-1:0] height_sample;

   modport source (output valid, output req_type, output height_sample, input ready);
   modport sink   (input valid, input req_type, input height_sample, output ready);
endinterface

interface sgb_rsp_if #(parameter int SAMPLE_BITS = sgb_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] smoothed_height;
   logic                   frame_done;

   modport source (output valid, output smoothed_height, output frame_done, input ready);
   modport sink   (input valid, input smoothed_height, input frame_done, output ready);
endinterface

>>> hw/rtl/separable_gaussian_blur_5tap.sv
// Top level of the separable 5-tap Gaussian blur of a square height map.
// Depends on sgb_pkg, sgb_channels (interfaces), sgb_ram, sgb_tap_cell, sgb_blur.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    req_type, height_sample
//   rsp_chan  out        valid/ready    smoothed_height, frame_done
//   csr_*     in/out     APB write/read side_length, coef_outer, coef_near, coef_center
//
// An ignored drain tick is dropped in the idle state, an item with no result steps through
// the vertical multiply and sum, and an item with a result then also through the horizontal
// multiply and sum; the single blur unit runs the vertical and then the horizontal pass,
// each as a multiply step and a sum step, after the registered line-store read.
// Reset is synchronous: control, positions and the column window clear at once;
// the line stores are not cleared.
// A held result stalls only the last step of the next item; req_chan is taken
// while a result waits.
`timescale 1ns / 1ps

module separable_gaussian_blur_5tap #(
   parameter int MAX_SIDE    = sgb_pkg::MAX_SIDE_DEF,
   parameter int SAMPLE_BITS = sgb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   sgb_req_if.sink                        req_chan,
   sgb_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sgb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sgb_pkg::*;

   localparam int COL_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int POS_W = $clog2(MAX_SIDE + 3);   // rows run to side + 2 while draining
   localparam int ROW_W = POS_W + 2;              // signed tap row offset

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_VMUL = 3'd1;
   localparam logic [2:0] ST_VSUM = 3'd2;
   localparam logic [2:0] ST_HMUL = 3'd3;
   localparam logic [2:0] ST_HSUM = 3'd4;

   // ---------------------------------------------------------------- CSR
   logic [SIDE_W-1:0] side_ff, side_in;
   coef_set_type      coef_ff, coef_in;
   logic              csr_wr;
   logic [1:0]        csr_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      side_in = side_ff;
      coef_in = coef_ff;
      if (csr_wr) begin
         unique case (csr_index)
            REG_SIDE:   side_in        = csr_pwdata[SIDE_W-1:0];
            REG_OUTER:  coef_in.outer  = csr_pwdata[COEF_W-1:0];
            REG_NEAR:   coef_in.near   = csr_pwdata[COEF_W-1:0];
            REG_CENTER: coef_in.center = csr_pwdata[COEF_W-1:0];
            default:    side_in        = side_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_SIDE:   csr_prdata = CSR_DATA_W'(side_ff);
         REG_OUTER:  csr_prdata = CSR_DATA_W'(coef_ff.outer);
         REG_NEAR:   csr_prdata = CSR_DATA_W'(coef_ff.near);
         REG_CENTER: csr_prdata = CSR_DATA_W'(coef_ff.center);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff        <= SIDE_RESET;
         coef_ff.outer  <= OUTER_RESET;
         coef_ff.near   <= NEAR_RESET;
         coef_ff.center <= CENTER_RESET;
      end else begin
         side_ff <= side_in;
         coef_ff <= coef_in;
      end
   end

   // ----------------------------------------------------- effective side
   logic [POS_W-1:0] side_eff;
   logic [POS_W-1:0] last_pos;
   logic [POS_W-1:0] drain_row;

   always_comb begin
      if (side_ff < SIDE_W'(MIN_SIDE)) begin
         side_eff = POS_W'(MIN_SIDE);
      end else if (32'(side_ff) > MAX_SIDE) begin
         side_eff = POS_W'(MAX_SIDE);
      end else begin
         side_eff = POS_W'(side_ff);
      end
   end

   assign last_pos  = side_eff - POS_W'(1);
   assign drain_row = side_eff + POS_W'(2);

   // --------------------------------------------------- control and state
   logic [2:0]             state_ff, state_in;
   logic [COL_W-1:0]       in_col_ff, in_col_in;
   logic [POS_W-1:0]       in_row_ff, in_row_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_height_ff, rsp_height_in;
   logic                   rsp_done_ff, rsp_done_in;

   logic             accept;
   logic             noop;
   logic [POS_W-1:0] x_wide;
   logic [POS_W-1:0] y_eff;
   logic [COL_W-1:0] x_eff;
   logic             out_free;

   // Clamp the stored position to the current side before use; the clamped
   // value is written back even when the item is dropped.
   always_comb begin
      x_wide = POS_W'(in_col_ff);
      if (x_wide > last_pos) begin
         x_wide = last_pos;
      end
      y_eff = (in_row_ff > drain_row) ? drain_row : in_row_ff;
      if (y_eff == drain_row && x_wide > POS_W'(1)) begin
         x_wide = POS_W'(1);
      end
      x_eff = COL_W'(x_wide);
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   // drain tick inside the frame: drop it
   assign noop           = (y_eff < side_eff) && req_chan.req_type;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // ----------------------------------------------------- output position
   logic             col_two;
   logic             has_out;
   logic [COL_W-1:0] ocol;
   logic [POS_W-1:0] orow;
   logic [COL_W-1:0] last_col;
   logic [COL_W-1:0] next_last_col;
   logic             done;

   assign last_col      = COL_W'(last_pos);
   assign next_last_col = COL_W'(side_eff - POS_W'(2));
   assign col_two       = (in_col_ff >= COL_W'(2));
   assign has_out       = (in_row_ff > POS_W'(2)) || (in_row_ff == POS_W'(2) && col_two);

   // The first two columns of a row finish the previous output row.
   assign ocol = col_two ? (in_col_ff - COL_W'(2))
                         : COL_W'(side_eff - POS_W'(2) + POS_W'(in_col_ff));
   assign orow = col_two ? (in_row_ff - POS_W'(2)) : (in_row_ff - POS_W'(3));
   assign done = (orow == last_pos) && (ocol == last_col);

   // advance to the next input position
   logic [COL_W-1:0] adv_col;
   logic [POS_W-1:0] adv_row;

   always_comb begin
      if (POS_W'(in_col_ff) + POS_W'(1) >= side_eff) begin
         adv_col = '0;
         adv_row = in_row_ff + POS_W'(1);
      end else begin
         adv_col = in_col_ff + COL_W'(1);
         adv_row = in_row_ff;
      end
   end

   // ---------------------------------------------------------- line stores
   logic [ROW_SLOTS-1:0][SAMPLE_BITS-1:0] ram_rd;

   for (genvar slot = 0; slot < ROW_SLOTS; slot++) begin : g_store
      logic wr_en;

      assign wr_en = accept && !noop && (y_eff < side_eff) && (y_eff[1:0] == 2'(slot));

      sgb_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (MAX_SIDE)
      ) u_store (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (x_eff),
         .wr_data (req_chan.height_sample),
         .rd_en   (accept && !noop),
         .rd_addr (x_eff),
         .rd_data (ram_rd[slot])
      );
   end

   // ------------------------------------------------------ vertical taps
   logic [TAPS-1:0][SAMPLE_BITS-1:0] vtap;

   always_comb begin
      logic [ROW_W-1:0] row_k;
      logic [POS_W-1:0] row_c;
      for (int k = 0; k < TAPS; k++) begin
         row_k = ROW_W'(in_row_ff) + ROW_W'(k) - ROW_W'(4);
         if (row_k[ROW_W-1]) begin
            row_c = '0;
         end else if (row_k[POS_W:0] > {1'b0, last_pos}) begin
            row_c = last_pos;
         end else begin
            row_c = row_k[POS_W-1:0];
         end
         // the current row is the sample in hand, not yet in the store
         vtap[k] = (row_c == in_row_ff) ? smp_ff : ram_rd[row_c[1:0]];
      end
   end

   // ------------------------------------------------------- column window
   logic [SAMPLE_BITS-1:0]           blur_result;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] win;

   for (genvar i = 0; i < TAPS; i++) begin : g_window
      logic [SAMPLE_BITS-1:0] cell_in;

      if (i == TAPS - 1) begin : g_newest
         assign cell_in = blur_result;
      end else begin : g_older
         assign cell_in = win[i+1];
      end

      sgb_tap_cell #(
         .WIDTH (SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (state_ff == ST_VSUM),
         .data_in  (cell_in),
         .data_out (win[i])
      );
   end

   // ---------------------------------------------------- horizontal taps
   logic [TAPS-1:0][SAMPLE_BITS-1:0] htap;

   always_comb begin
      logic [2:0] idx;
      for (int k = 0; k < TAPS; k++) begin
         idx = 3'(k);
         // clamp to edge: repeat the border column
         if (ocol == '0 && k < 2) begin
            idx = 3'd2;
         end else if (ocol == COL_W'(1) && k == 0) begin
            idx = 3'd1;
         end else if (ocol == last_col && k > 2) begin
            idx = 3'd2;
         end else if (ocol == next_last_col && k == 4) begin
            idx = 3'd3;
         end
         htap[k] = win[idx];
      end
   end

   // ------------------------------------------------------ blur unit
   logic [TAPS-1:0][SAMPLE_BITS-1:0] blur_tap;

   assign blur_tap = (state_ff == ST_HMUL) ? htap : vtap;

   sgb_blur #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_blur (
      .clock  (clock),
      .load   ((state_ff == ST_VMUL) || (state_ff == ST_HMUL)),
      .coef   (coef_ff),
      .tap    (blur_tap),
      .result (blur_result)
   );

   // ------------------------------------------------------ sequencer
   always_comb begin
      state_in      = state_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      smp_in        = smp_ff;
      rsp_height_in = rsp_height_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               in_col_in = x_eff;
               in_row_in = y_eff;
               smp_in    = req_chan.height_sample;
               state_in  = noop ? ST_IDLE : ST_VMUL;
            end
         end
         ST_VMUL: begin
            state_in = ST_VSUM;
         end
         ST_VSUM: begin
            if (has_out) begin
               state_in = ST_HMUL;
            end else begin
               in_col_in = adv_col;
               in_row_in = adv_row;
               state_in  = ST_IDLE;
            end
         end
         ST_HMUL: begin
            state_in = ST_HSUM;
         end
         ST_HSUM: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = blur_result;
               rsp_done_in   = done;
               if (done) begin
                  in_col_in = '0;
                  in_row_in = '0;
               end else begin
                  in_col_in = adv_col;
                  in_row_in = adv_row;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff        <= smp_in;
      rsp_height_ff <= rsp_height_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.smoothed_height = rsp_height_ff;
   assign rsp_chan.frame_done      = rsp_done_ff;

endmodule

>>> hw/rtl/sgb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. Uses sgb_pkg defaults.
`timescale 1ns / 1ps

module sgb_ram #(
   parameter int WIDTH = sgb_pkg::SAMPLE_BITS_DEF,
   parameter int DEPTH = sgb_pkg::MAX_SIDE_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sgb_tap_cell.sv
// One cell of the column window chain: holds one vertical result and
// hands it to its older neighbor on every shift. Uses sgb_pkg defaults.
`timescale 1ns / 1ps

module sgb_tap_cell #(
   parameter int WIDTH = sgb_pkg::SAMPLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff;
   logic [WIDTH-1:0] tap_in;

   assign tap_in = shift_en ? data_in : tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in;
      end
   end

   assign data_out = tap_ff;

endmodule

>>> hw/rtl/sgb_blur.sv
// Shared 5-tap symmetric blur unit: registered products, then sum, round, saturate.
// Depends on sgb_pkg (coefficient set type, rounding constants).
`timescale 1ns / 1ps

module sgb_blur #(
   parameter int SAMPLE_BITS = sgb_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    load,
   input  sgb_pkg::coef_set_type                   coef,
   input  logic [sgb_pkg::TAPS-1:0][SAMPLE_BITS-1:0] tap,
   output logic [SAMPLE_BITS-1:0]                  result
);
   import sgb_pkg::*;

   localparam int PAIR_W  = SAMPLE_BITS + 1;
   localparam int PROD_W  = COEF_W + PAIR_W;
   localparam int ACC_W   = PROD_W + 2;
   localparam int SHIFT_W = ACC_W - FRAC_BITS;

   logic [PAIR_W-1:0]  pair_outer;
   logic [PAIR_W-1:0]  pair_near;
   logic [PROD_W-1:0]  outer_ff, outer_in;
   logic [PROD_W-1:0]  near_ff, near_in;
   logic [PROD_W-1:0]  center_ff, center_in;
   logic [ACC_W-1:0]   acc;
   logic [SHIFT_W-1:0] shifted;

   assign pair_outer = PAIR_W'(tap[0]) + PAIR_W'(tap[4]);
   assign pair_near  = PAIR_W'(tap[1]) + PAIR_W'(tap[3]);

   assign outer_in  = load ? {{PAIR_W{1'b0}}, coef.outer} * {{COEF_W{1'b0}}, pair_outer}
                           : outer_ff;
   assign near_in   = load ? {{PAIR_W{1'b0}}, coef.near} * {{COEF_W{1'b0}}, pair_near}
                           : near_ff;
   assign center_in = load ? {{PAIR_W{1'b0}}, coef.center}
                             * {{(COEF_W + 1){1'b0}}, tap[2]}
                           : center_ff;

   always_ff @(posedge clock) begin
      outer_ff  <= outer_in;
      near_ff   <= near_in;
      center_ff <= center_in;
   end

   assign acc     = ACC_W'(outer_ff) + ACC_W'(near_ff) + ACC_W'(center_ff)
                  + ACC_W'(ROUND_BIAS);
   assign shifted = acc[ACC_W-1:FRAC_BITS];

   // saturate at full scale
   assign result = (|shifted[SHIFT_W-1:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}}
                                                    : shifted[SAMPLE_BITS-1:0];

endmodule

>>> test/sgb_blur_checker.sv
// Checker for the 5-tap Gaussian blur: watches the request, result and CSR traffic,
// predicts each blurred pixel and compares it with what the block returns.
// Depends on sgb_pkg and the channel interfaces in sgb_channels.
`timescale 1ns / 1ps

module sgb_blur_checker (
   input  logic                           clock,
   input  logic                           reset,
   sgb_req_if                             req_chan,
   sgb_rsp_if                             rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sgb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sgb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             pixels_outstanding
);
   import sgb_pkg::*;

   localparam int SAMPLE_MAX = (1 << SAMPLE_BITS_DEF) - 1;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      logic [SAMPLE_BITS_DEF-1:0] height;
      logic                       done;
   } pixel_type;

   logic [SIDE_W-1:0]          side_reg;
   logic [COEF_W-1:0]          w_outer;
   logic [COEF_W-1:0]          w_near;
   logic [COEF_W-1:0]          w_center;
   logic [SAMPLE_BITS_DEF-1:0] line_mem [ROW_SLOTS*MAX_SIDE_DEF];
   logic [SAMPLE_BITS_DEF-1:0] col_win [TAPS];
   int                         in_x;
   int                         in_y;
   pixel_type                  expected_pixels [$];

   function automatic int clip(input int v, input int lo, input int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   // one symmetric pass: round to nearest, saturate
   function automatic logic [SAMPLE_BITS_DEF-1:0] weigh(
      input logic [SAMPLE_BITS_DEF-1:0] a, b, c, d, e);
      logic [63:0] acc;
      acc = 64'(w_outer) * (64'(a) + 64'(e)) + 64'(w_near) * (64'(b) + 64'(d))
          + 64'(w_center) * 64'(c);
      acc = (acc + 64'(ROUND_BIAS)) >> FRAC_BITS;
      return (acc > 64'(SAMPLE_MAX)) ? '1 : acc[SAMPLE_BITS_DEF-1:0];
   endfunction

   task automatic blur_step(input logic kind, input logic [SAMPLE_BITS_DEF-1:0] value);
      int                         s, y, x, r, col, orow, ocol;
      logic [SAMPLE_BITS_DEF-1:0] tap [TAPS];
      pixel_type                  px;
      s = clip(int'(side_reg), MIN_SIDE, MAX_SIDE_DEF);
      // pull positions back inside a side that shrank mid-frame
      if (in_x >= s) in_x = s - 1;
      if (in_y > s + 2) in_y = s + 2;
      if (in_y == s + 2 && in_x > 1) in_x = 1;
      y = in_y;
      x = in_x;
      if (y < s && kind) return;
      for (int k = 0; k < TAPS; k++) begin
         r = clip(y - 4 + k, 0, s - 1);
         tap[k] = (r == y) ? value : line_mem[(r % ROW_SLOTS) * MAX_SIDE_DEF + x];
      end
      if (y < s) line_mem[(y % ROW_SLOTS) * MAX_SIDE_DEF + x] = value;
      for (int k = 0; k < TAPS - 1; k++) col_win[k] = col_win[k + 1];
      col_win[TAPS - 1] = weigh(tap[0], tap[1], tap[2], tap[3], tap[4]);
      if (y > 2 || (y == 2 && x >= 2)) begin
         if (x >= 2) begin
            orow = y - 2;
            ocol = x - 2;
         end else begin
            orow = y - 3;
            ocol = s - 2 + x;
         end
         for (int k = 0; k < TAPS; k++) begin
            col = clip(ocol + k - 2, 0, s - 1);
            tap[k] = col_win[clip(2 + col - ocol, 0, TAPS - 1)];
         end
         px.height = weigh(tap[0], tap[1], tap[2], tap[3], tap[4]);
         px.done   = (orow == s - 1 && ocol == s - 1);
         expected_pixels.push_back(px);
         if (px.done) begin
            in_x = 0;
            in_y = 0;
            return;
         end
      end
      if (x + 1 >= s) begin
         in_x = 0;
         in_y = y + 1;
      end else begin
         in_x = x + 1;
      end
   endtask

   task automatic report_miss(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         side_reg = SIDE_RESET;
         w_outer  = OUTER_RESET;
         w_near   = NEAR_RESET;
         w_center = CENTER_RESET;
         foreach (col_win[k]) col_win[k] = '0;
         in_x = 0;
         in_y = 0;
         expected_pixels.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_pixels.size() == 0) begin
               report_miss($sformatf("unexpected pixel height %0d done %0d",
                                     rsp_chan.smoothed_height, rsp_chan.frame_done));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_chan.smoothed_height !== want.height ||
                   rsp_chan.frame_done !== want.done)
                  report_miss($sformatf("pixel height %0d done %0d, expected height %0d done %0d",
                                        rsp_chan.smoothed_height, rsp_chan.frame_done,
                                        want.height, want.done));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_ADDR_W-1:2])
               REG_SIDE:   side_reg = csr_pwdata[SIDE_W-1:0];
               REG_OUTER:  w_outer  = csr_pwdata[COEF_W-1:0];
               REG_NEAR:   w_near   = csr_pwdata[COEF_W-1:0];
               REG_CENTER: w_center = csr_pwdata[COEF_W-1:0];
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready)
            blur_step(req_chan.req_type, req_chan.height_sample);
      end
      pixels_outstanding = expected_pixels.size();
   end

endmodule

>>> test/separable_gaussian_blur_5tap_tb.sv
// Top of the blur testbench: clock, reset, CSR setup and height-map frames, plus
// the verdict. Depends on sgb_pkg, sgb_channels, the blur RTL and sgb_blur_checker.
`timescale 1ns / 1ps

module separable_gaussian_blur_5tap_tb;
   import sgb_pkg::*;

   localparam int HALF_PERIOD     = 4;
   localparam int RESET_CYCLES    = 8;
   localparam int IDLE_PCT        = 21;
   localparam int NOISE_PCT       = 5;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 500;
   localparam int TIMEOUT_NS      = 5_000_000;
   localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS_DEF) - 1;

   typedef enum int {PAT_RANDOM, PAT_EXTREME, PAT_ALTERNATE, PAT_HIGH} pattern_type;
   typedef enum int {COEF_RANDOM, COEF_GAUSS, COEF_ZERO, COEF_FULL, COEF_DEFAULT} coef_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sgb_req_if req_chan ();
   sgb_rsp_if rsp_chan ();

   int mismatch_count;
   int pixels_outstanding;
   int items_sent;
   int walk_count;
   int side_now;
   bit calm;           // no idling on either side while set
   bit hold_off_req;   // ask the receiver for one long stall

   always #HALF_PERIOD clock = ~clock;

   separable_gaussian_blur_5tap uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sgb_blur_checker blur_check (
      .clock              (clock),
      .reset              (reset),
      .req_chan           (req_chan),
      .rsp_chan           (rsp_chan),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatch_count     (mismatch_count),
      .pixels_outstanding (pixels_outstanding)
   );

   function automatic int eff_side(input int v);
      return (v < MIN_SIDE) ? MIN_SIDE : (v > MAX_SIDE_DEF) ? MAX_SIDE_DEF : v;
   endfunction

   function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample(input pattern_type pattern);
      case (pattern)
         PAT_EXTREME: return ($urandom_range(1) == 1) ? '1 : '0;
         PAT_ALTERNATE: begin
            walk_count++;
            return walk_count[0] ? '1 : '0;
         end
         PAT_HIGH: return SAMPLE_BITS_DEF'(SAMPLE_MAX - $urandom_range(255));
         default: return SAMPLE_BITS_DEF'($urandom_range(SAMPLE_MAX));
      endcase
   endfunction

   // Offer one item from a falling edge; return at the falling edge after it is taken,
   // with valid still high so a following item keeps the channel busy.
   task automatic send_item(input logic kind, input logic [SAMPLE_BITS_DEF-1:0] value);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= kind;
      req_chan.height_sample <= value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Samples of the frame, with the odd drain tick in between that the block must drop.
   task automatic send_samples(input int count, input pattern_type pattern, input int noise_pct);
      repeat (count) begin
         if ($urandom_range(99) < noise_pct) send_item(1'b1, SAMPLE_BITS_DEF'($urandom));
         send_item(1'b0, pick_sample(pattern));
      end
      items_sent += count;
   endtask

   // Past the last row a sample counts as a drain tick too, so mix both.
   task automatic send_drains(input int count);
      repeat (count) send_item($urandom_range(99) < 70, SAMPLE_BITS_DEF'($urandom));
      items_sent += count;
   endtask

   // APB write: setup phase, access phase, then an idle phase with psel low.
   task automatic write_reg(input logic [1:0] index, input int value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, wait for every pixel owed, then give the pipeline time to empty
   // of items that produce nothing.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pixels_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure(input int side, input int outer, input int near, input int center);
      settle();
      write_reg(REG_SIDE, side);
      write_reg(REG_OUTER, outer);
      write_reg(REG_NEAR, near);
      write_reg(REG_CENTER, center);
      side_now = side;
   endtask

   // One frame at the current side. With cut_at >= 0, stop after cut_at samples, shrink
   // the side to cut_side while idle and finish the frame at the new size.
   // The cut must fall on a row below the new side so no unwritten store entry is read.
   task automatic run_frame(input int cut_at, input int cut_side, input pattern_type pattern);
      int s, y, x, rest;
      s = eff_side(side_now);
      if (cut_at < 0) begin
         send_samples(s * s, pattern, NOISE_PCT);
         send_drains(2 * s + 2);
      end else begin
         send_samples(cut_at, pattern, NOISE_PCT);
         settle();
         write_reg(REG_SIDE, cut_side);
         side_now = cut_side;
         y = cut_at / s;
         x = cut_at % s;
         s = eff_side(cut_side);
         // a column past the new side clamps to the last column
         rest = s * s - (y * s + ((x < s) ? x : s - 1));
         send_samples(rest, pattern, NOISE_PCT);
         send_drains(2 * s + 2);
      end
   endtask

   // Receiver: random stalls, a calm stretch, and one long counted hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            repeat (HOLD_OFF_CYCLES) begin
               rsp_chan.ready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         @(negedge clock);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int            side_val, new_side, iter, s;
      int            outer, near, center;
      coef_mode_type mode;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = 1'b0;
      req_chan.height_sample = '0;
      calm         = 1'b0;
      hold_off_req = 1'b0;
      walk_count   = 0;
      items_sent   = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed frame: side 0 acts as the minimum, full-scale weights saturate,
      // samples alternate between the extremes. Stall the receiver long enough that
      // the first results back up and the input stalls while items keep coming.
      configure(0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      hold_off_req = 1'b1;
      send_samples(12, PAT_ALTERNATE, 0);
      send_item(1'b1, '1);                // drain tick inside the frame: dropped
      send_samples(MIN_SIDE * MIN_SIDE - 12, PAT_ALTERNATE, 0);
      send_item(1'b0, '1);                // sample past the last row acts as a drain tick
      send_drains(2 * MIN_SIDE + 1);

      // Oversized side clamps to the maximum. Start a full-width frame, then shrink
      // the side partway along the first row so the column clamps to the new last one.
      configure(9'h1FF, $urandom_range(0, 2000), $urandom_range(5000, 16000), 40000);
      new_side = $urandom_range(MIN_SIDE, MIN_SIDE + 2);
      run_frame($urandom_range(8, MAX_SIDE_DEF - 1), new_side, PAT_RANDOM);

      // Random frames: small sides, assorted weights, now and then a mid-frame shrink.
      iter = 0;
      while (items_sent < RANDOM_ITEMS) begin
         calm = (iter == 0);
         side_val = ($urandom_range(7) == 0) ? $urandom_range(0, MIN_SIDE - 1)
                                             : $urandom_range(MIN_SIDE, 12);
         mode = coef_mode_type'($urandom_range(4));
         case (mode)
            COEF_GAUSS: begin
               outer  = $urandom_range(0, 2000);
               near   = $urandom_range(5000, 16000);
               center = (1 << FRAC_BITS) - 2 * outer - 2 * near;
            end
            COEF_ZERO: begin
               outer = 0; near = 0; center = 0;
            end
            COEF_FULL: begin
               outer = SAMPLE_MAX; near = SAMPLE_MAX; center = SAMPLE_MAX;
            end
            COEF_DEFAULT: begin
               outer = OUTER_RESET; near = NEAR_RESET; center = CENTER_RESET;
            end
            default: begin
               outer  = $urandom_range(SAMPLE_MAX);
               near   = $urandom_range(SAMPLE_MAX);
               center = $urandom_range(SAMPLE_MAX);
            end
         endcase
         configure(side_val, outer, near, center);
         s = eff_side(side_val);
         if (s > MIN_SIDE && $urandom_range(3) == 0) begin
            new_side = $urandom_range(MIN_SIDE, s - 1);
            run_frame($urandom_range(0, new_side * s - 1), new_side,
                      pattern_type'($urandom_range(3)));
         end else begin
            run_frame(-1, -1, pattern_type'($urandom_range(3)));
         end
         iter++;
      end
      calm = 1'b0;

      // wait out every owed pixel plus the pipeline, then judge
      settle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> separable_gaussian_blur_5tap.f
hw/rtl/sgb_pkg.sv
hw/rtl/sgb_channels.sv
hw/rtl/sgb_ram.sv
hw/rtl/sgb_tap_cell.sv
hw/rtl/sgb_blur.sv
hw/rtl/separable_gaussian_blur_5tap.sv
test/sgb_blur_checker.sv
test/separable_gaussian_blur_5tap_tb.sv
